// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define OEIM_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, checked during reset too.
`define OEIM_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define OEIM_ASSERT_IMP(label, a, c)
`define OEIM_ASSERT_NXT(label, a, c)
`endif
`endif

// ===== rtl/oeim_pkg.sv =====
// Package: default sizes, register indexes and shared types of the index map.
`default_nettype none
package oeim_pkg;
  localparam int DEF_INDEX_BITS      = 32;
  localparam int DEF_MAX_CELL_POINTS = 1024;
  localparam int DEF_MAX_CELLS       = 256;
  localparam int DEF_MAX_LAYERS      = 16;

  localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_PAD_X        = 3'd2;
  localparam logic [2:0] REG_PAD_Y        = 3'd3;
  localparam logic [2:0] REG_CELLS_ACROSS = 3'd4;
  localparam logic [2:0] REG_CELLS_DOWN   = 3'd5;
  localparam logic [2:0] REG_LAYER_COUNT  = 3'd6;

  localparam logic [1:0] PHASE_NONE = 2'b00;
  localparam logic [1:0] PHASE_UP   = 2'b01;  // +1
  localparam logic [1:0] PHASE_DOWN = 2'b11;  // -1

  typedef struct packed {
    logic [1:0] phase_y;
    logic [1:0] phase_x;
    logic [1:0] margin_power;
  } oeim_wt_t;
endpackage
`default_nettype wire

// ===== rtl/oeim_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module oeim_div
  import oeim_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [DW-1:0]      out_rem,
  output logic [SW-1:0]      out_side
);
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [SW-1:0] side_r [NW];
  logic          v_r    [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = in_num;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = v_r[s-1];
    end

    assign trial = {rem_in, quo_in[NW-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? DW'(trial - {1'b0, den}) : DW'(trial);
        quo_r[s]  <= {quo_in[NW-2:0], take};
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_rem   = rem_r[NW-1];
  assign out_side  = side_r[NW-1];
endmodule
`default_nettype wire

// ===== rtl/overlap_extension_index_map.sv =====
// Top level: overlap extension index map, padded row index to unpadded column index.
`default_nettype none
// Takes one row index of the padded, overlapping cell grid per clock while
// in_tready is high and returns its column index in the unpadded periodic
// grid plus the weight exponents (margin count and Bloch phase signs along
// x and y). Throughput is one request per clock while the output is not
// stalled. The mixed-radix split runs through five pipelined restoring
// dividers, one quotient bit per stage, for layer, x, y, cell x and cell y,
// followed by one margin mapping stage and four multiply-add stages that
// rebuild the column index. The whole pipe holds when a result waits at the
// output; in_tready falls only then. Registers sit on the APB port at
// 4*index and may only be changed while the block is idle.
// Out-of-range register values are clamped (zero sizes count as one).
module overlap_extension_index_map
  import oeim_pkg::*;
#(
  parameter int INDEX_BITS      = DEF_INDEX_BITS,
  parameter int MAX_CELL_POINTS = DEF_MAX_CELL_POINTS,
  parameter int MAX_CELLS       = DEF_MAX_CELLS,
  parameter int MAX_LAYERS      = DEF_MAX_LAYERS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] row_index
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] column_index
  output logic [7:0]       out_tuser,   // [1:0] margin_power, [3:2] phase_x,
                                        // [5:4] phase_y, [7:6] zero
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int IW  = INDEX_BITS;
  localparam int CPW = $clog2(MAX_CELL_POINTS + 1);
  localparam int MXW = $clog2(3 * MAX_CELL_POINTS + 1);
  localparam int CW  = $clog2(MAX_CELLS + 1);
  localparam int LW  = $clog2(MAX_LAYERS + 1);

  // ---------------- configuration registers ----------------
  logic [10:0] cell_width_r, cell_height_r, pad_x_r, pad_y_r;
  logic [8:0]  cells_across_r, cells_down_r;
  logic [4:0]  layer_count_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r   <= 11'd1;
      cell_height_r  <= 11'd1;
      pad_x_r        <= 11'd0;
      pad_y_r        <= 11'd0;
      cells_across_r <= 9'd1;
      cells_down_r   <= 9'd1;
      layer_count_r  <= 5'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CELL_WIDTH:   cell_width_r   <= cfg_pwdata[10:0];
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_pwdata[10:0];
        REG_PAD_X:        pad_x_r        <= cfg_pwdata[10:0];
        REG_PAD_Y:        pad_y_r        <= cfg_pwdata[10:0];
        REG_CELLS_ACROSS: cells_across_r <= cfg_pwdata[8:0];
        REG_CELLS_DOWN:   cells_down_r   <= cfg_pwdata[8:0];
        REG_LAYER_COUNT:  layer_count_r  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CELL_WIDTH:   cfg_prdata = 32'(cell_width_r);
      REG_CELL_HEIGHT:  cfg_prdata = 32'(cell_height_r);
      REG_PAD_X:        cfg_prdata = 32'(pad_x_r);
      REG_PAD_Y:        cfg_prdata = 32'(pad_y_r);
      REG_CELLS_ACROSS: cfg_prdata = 32'(cells_across_r);
      REG_CELLS_DOWN:   cfg_prdata = 32'(cells_down_r);
      REG_LAYER_COUNT:  cfg_prdata = 32'(layer_count_r);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- clamped sizes, registered ----------------
  function automatic logic [31:0] clampv(input logic [31:0] v, input logic [31:0] lo,
                                         input logic [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [CPW-1:0] nx_r, ny_r, px_r, py_r;
  logic [MXW-1:0] mx_r, my_r;
  logic [CW-1:0]  ncx_r, ncy_r;
  logic [LW-1:0]  nl_r;
  logic [CPW-1:0] nx_nxt, ny_nxt, px_nxt, py_nxt;

  always_comb begin
    nx_nxt = CPW'(clampv(32'(cell_width_r), 32'd1, 32'(MAX_CELL_POINTS)));
    ny_nxt = CPW'(clampv(32'(cell_height_r), 32'd1, 32'(MAX_CELL_POINTS)));
    px_nxt = CPW'(clampv(32'(pad_x_r), 32'd0, 32'(MAX_CELL_POINTS)));
    py_nxt = CPW'(clampv(32'(pad_y_r), 32'd0, 32'(MAX_CELL_POINTS)));
  end

  always_ff @(posedge clk) begin
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    mx_r  <= MXW'({px_nxt, 1'b0}) + MXW'(nx_nxt);
    my_r  <= MXW'({py_nxt, 1'b0}) + MXW'(ny_nxt);
    ncx_r <= CW'(clampv(32'(cells_across_r), 32'd1, 32'(MAX_CELLS)));
    ncy_r <= CW'(clampv(32'(cells_down_r), 32'd1, 32'(MAX_CELLS)));
    nl_r  <= LW'(clampv(32'(layer_count_r), 32'd1, 32'(MAX_LAYERS)));
  end

  // ---------------- pipeline control ----------------
  // Every stage moves together; only a waiting result holds the pipe.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic          s0_v_r;
  logic [IW-1:0] s0_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_k_r <= IW'(in_tdata);
    end
  end

  // ---------------- mixed-radix split ----------------
  logic          d1_v, d2_v, d3_v, d4_v, d5_v;
  logic [IW-1:0] d1_q, d2_q, d3_q, d4_q;
  logic [LW-1:0] d1_r, il5;
  logic [MXW-1:0] d2_r, d3_r, ix5, iy5;
  logic [CW-1:0] d4_r, icy5, icx5;
  logic [LW-1:0] il2;
  logic [LW+MXW-1:0] side3;
  logic [LW+2*MXW-1:0] side4;

  oeim_div #(.NW(IW), .DW(LW), .SW(1)) u_div_layer (
    .clk, .rst_n, .en,
    .in_valid(s0_v_r), .in_num(s0_k_r), .den(nl_r), .in_side(1'b0),
    .out_valid(d1_v), .out_quo(d1_q), .out_rem(d1_r), .out_side()
  );

  oeim_div #(.NW(IW), .DW(MXW), .SW(LW)) u_div_x (
    .clk, .rst_n, .en,
    .in_valid(d1_v), .in_num(d1_q), .den(mx_r), .in_side(d1_r),
    .out_valid(d2_v), .out_quo(d2_q), .out_rem(d2_r), .out_side(il2)
  );

  oeim_div #(.NW(IW), .DW(MXW), .SW(LW + MXW)) u_div_y (
    .clk, .rst_n, .en,
    .in_valid(d2_v), .in_num(d2_q), .den(my_r), .in_side({d2_r, il2}),
    .out_valid(d3_v), .out_quo(d3_q), .out_rem(d3_r), .out_side(side3)
  );

  oeim_div #(.NW(IW), .DW(CW), .SW(LW + 2 * MXW)) u_div_cx (
    .clk, .rst_n, .en,
    .in_valid(d3_v), .in_num(d3_q), .den(ncx_r), .in_side({d3_r, side3}),
    .out_valid(d4_v), .out_quo(d4_q), .out_rem(d4_r), .out_side(side4)
  );

  // cell y is only needed modulo the cell count
  oeim_div #(.NW(IW), .DW(CW), .SW(LW + 2 * MXW + CW)) u_div_cy (
    .clk, .rst_n, .en,
    .in_valid(d4_v), .in_num(d4_q), .den(ncy_r), .in_side({d4_r, side4}),
    .out_valid(d5_v), .out_quo(), .out_rem(icy5),
    .out_side({icx5, iy5, ix5, il5})
  );

  // ---------------- margin mapping ----------------
  function automatic logic [IW-1:0] axis_j(input logic [MXW-1:0] p,
                                           input logic [CPW-1:0] n,
                                           input logic [CPW-1:0] pad);
    if (p < MXW'(pad)) return IW'(p) + IW'(n) - IW'(pad);
    if (p >= MXW'(pad) + MXW'(n)) return IW'(p) - (IW'(pad) + IW'(n));
    return IW'(p) - IW'(pad);
  endfunction

  function automatic logic [CW-1:0] axis_jc(input logic [MXW-1:0] p,
                                            input logic [CW-1:0] c,
                                            input logic [CPW-1:0] n,
                                            input logic [CPW-1:0] pad,
                                            input logic [CW-1:0] cells);
    if (p < MXW'(pad)) return (c == '0) ? cells - 1'b1 : c - 1'b1;
    if (p >= MXW'(pad) + MXW'(n)) return ((CW + 1)'(c) + 1'b1 >= (CW + 1)'(cells)) ? '0
                                                                         : c + 1'b1;
    return c;
  endfunction

  function automatic logic [1:0] axis_ph(input logic [MXW-1:0] p,
                                         input logic [CW-1:0] c,
                                         input logic [CPW-1:0] n,
                                         input logic [CPW-1:0] pad,
                                         input logic [CW-1:0] cells);
    if (p < MXW'(pad)) return (c == '0) ? PHASE_UP : PHASE_NONE;
    if (p >= MXW'(pad) + MXW'(n)) return ((CW + 1)'(c) + 1'b1 >= (CW + 1)'(cells)) ?
                                          PHASE_DOWN : PHASE_NONE;
    return PHASE_NONE;
  endfunction

  logic          m_v_r;
  logic [IW-1:0] m_jx_r, m_jy_r;
  logic [CW-1:0] m_jcx_r, m_jcy_r;
  logic [LW-1:0] m_il_r;
  oeim_wt_t      m_wt_r;
  logic          in_mx, in_my;

  assign in_mx = (ix5 < MXW'(px_r)) || (ix5 >= MXW'(px_r) + MXW'(nx_r));
  assign in_my = (iy5 < MXW'(py_r)) || (iy5 >= MXW'(py_r) + MXW'(ny_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= d5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_jx_r  <= axis_j(ix5, nx_r, px_r);
      m_jy_r  <= axis_j(iy5, ny_r, py_r);
      m_jcx_r <= axis_jc(ix5, icx5, nx_r, px_r, ncx_r);
      m_jcy_r <= axis_jc(iy5, icy5, ny_r, py_r, ncy_r);
      m_il_r  <= il5;
      m_wt_r.margin_power <= 2'(in_mx) + 2'(in_my);
      m_wt_r.phase_x      <= axis_ph(ix5, icx5, nx_r, px_r, ncx_r);
      m_wt_r.phase_y      <= axis_ph(iy5, icy5, ny_r, py_r, ncy_r);
    end
  end

  // ---------------- column rebuild, one multiply-add a stage ----------------
  logic            c1_v_r, c2_v_r, c3_v_r;
  logic [2*CW-1:0] c1_col_r;
  logic [IW-1:0]   c2_col_r, c3_col_r;
  logic [IW-1:0]   c1_jx_r, c1_jy_r, c2_jx_r;
  logic [LW-1:0]   c1_il_r, c2_il_r, c3_il_r;
  oeim_wt_t        c1_wt_r, c2_wt_r, c3_wt_r;
  logic [31:0]     out_col_r;
  oeim_wt_t        out_wt_r;
  logic            out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      c3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r  <= m_v_r;
      c2_v_r  <= c1_v_r;
      c3_v_r  <= c2_v_r;
      out_v_r <= c3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_col_r <= (2 * CW)'(m_jcx_r) + (2 * CW)'(ncx_r) * (2 * CW)'(m_jcy_r);
      c1_jx_r  <= m_jx_r;
      c1_jy_r  <= m_jy_r;
      c1_il_r  <= m_il_r;
      c1_wt_r  <= m_wt_r;
      c2_col_r <= c1_jy_r + IW'(IW'(ny_r) * IW'(c1_col_r));
      c2_jx_r  <= c1_jx_r;
      c2_il_r  <= c1_il_r;
      c2_wt_r  <= c1_wt_r;
      c3_col_r <= c2_jx_r + IW'(IW'(nx_r) * c2_col_r);
      c3_il_r  <= c2_il_r;
      c3_wt_r  <= c2_wt_r;
      out_col_r <= 32'(IW'(c3_il_r) + IW'(IW'(nl_r) * c3_col_r));
      out_wt_r  <= c3_wt_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_col_r;
  assign out_tuser  = {2'b00, out_wt_r};

  // ---------------- assertions ----------------
`include "assert_macros.svh"
  `OEIM_ASSERT_NXT(a_empty_after_reset, !rst_n, !out_tvalid)
  `OEIM_ASSERT_IMP(a_phase_x_needs_margin, out_tvalid && out_tuser[3:2] != PHASE_NONE,
                   out_tuser[1:0] != 2'b00)
  `OEIM_ASSERT_IMP(a_phase_y_needs_margin, out_tvalid && out_tuser[5:4] != PHASE_NONE,
                   out_tuser[1:0] != 2'b00)
  `OEIM_ASSERT_IMP(a_margin_range, out_tvalid, out_tuser[1:0] != 2'b11)
endmodule
`default_nettype wire

// ===== tb/overlap_extension_index_map_checker.sv =====
// Checker: watches both channels, predicts each column mapping and compares.
`timescale 1ns / 1ps
module overlap_extension_index_map_checker
  import oeim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic [7:0]  out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [31:0] col;
    logic [7:0]  wt;
  } mapping_t;

  mapping_t    mapping_q[$];
  logic [10:0] r_cw, r_ch, r_px, r_py;
  logic [8:0]  r_ncx, r_ncy;
  logic [4:0]  r_nl;

  assign pending = mapping_q.size();

  function automatic longint unsigned clampv(longint unsigned v, lo, hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // one axis: position p in padded cell c -> interior offset, target cell, margin count and phase
  function automatic void fold_axis(input longint unsigned p, c, n, pad, cells,
                                    output longint unsigned j, jc,
                                    inout int margin, output logic [1:0] ph);
    ph = PHASE_NONE;
    if (p < pad) begin
      j = p + n - pad;
      margin++;
      if (c == 0) begin
        jc = cells - 1;
        ph = PHASE_UP;
      end else jc = c - 1;
    end else if (p >= pad + n) begin
      j = p - (pad + n);
      margin++;
      if (c + 1 >= cells) begin
        jc = c + 1 - cells;
        ph = PHASE_DOWN;
      end else jc = c + 1;
    end else begin
      j = p - pad;
      jc = c;
    end
  endfunction

  function automatic mapping_t map_row(logic [31:0] row);
    longint unsigned nx, ny, px, py, ncx, ncy, nl, mx, my, k;
    longint unsigned il, ix, iy, icx, icy, jx, jy, jcx, jcy, col;
    int margin;
    logic [1:0] phx, phy;
    mapping_t m;
    nx = clampv(r_cw, 1, 1024);
    ny = clampv(r_ch, 1, 1024);
    px = clampv(r_px, 0, 1024);
    py = clampv(r_py, 0, 1024);
    ncx = clampv(r_ncx, 1, 256);
    ncy = clampv(r_ncy, 1, 256);
    nl = clampv(r_nl, 1, 16);
    mx = 2 * px + nx;
    my = 2 * py + ny;
    k = row;
    margin = 0;
    il = k % nl;   k = k / nl;
    ix = k % mx;   k = k / mx;
    iy = k % my;   k = k / my;
    icx = k % ncx; k = k / ncx;
    icy = k % ncy;
    fold_axis(ix, icx, nx, px, ncx, jx, jcx, margin, phx);
    fold_axis(iy, icy, ny, py, ncy, jy, jcy, margin, phy);
    col = il + nl * (jx + nx * (jy + ny * (jcx + ncx * jcy)));
    m.col = col[31:0];
    m.wt = {2'b00, phy, phx, 2'(margin)};
    return m;
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    mapping_t want;
    if (!rst_n) begin
      r_cw <= 11'd1; r_ch <= 11'd1; r_px <= '0; r_py <= '0;
      r_ncx <= 9'd1; r_ncy <= 9'd1; r_nl <= 5'd1;
      fail_count <= 0;
      mapping_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite)
        case (cfg_paddr[4:2])
          REG_CELL_WIDTH:   r_cw  <= cfg_pwdata[10:0];
          REG_CELL_HEIGHT:  r_ch  <= cfg_pwdata[10:0];
          REG_PAD_X:        r_px  <= cfg_pwdata[10:0];
          REG_PAD_Y:        r_py  <= cfg_pwdata[10:0];
          REG_CELLS_ACROSS: r_ncx <= cfg_pwdata[8:0];
          REG_CELLS_DOWN:   r_ncy <= cfg_pwdata[8:0];
          REG_LAYER_COUNT:  r_nl  <= cfg_pwdata[4:0];
          default: ;
        endcase
      if (in_tvalid && in_tready) mapping_q.push_back(map_row(in_tdata));
      if (out_tvalid && out_tready) begin
        if (mapping_q.size() == 0) report("unexpected result", {out_tdata, out_tuser}, 0);
        else begin
          want = mapping_q.pop_front();
          if (out_tdata !== want.col) report("column_index", out_tdata, want.col);
          if (out_tuser[1:0] !== want.wt[1:0]) report("margin_power", out_tuser[1:0], want.wt[1:0]);
          if (out_tuser[3:2] !== want.wt[3:2]) report("phase_x", out_tuser[3:2], want.wt[3:2]);
          if (out_tuser[5:4] !== want.wt[5:4]) report("phase_y", out_tuser[5:4], want.wt[5:4]);
          if (out_tuser[7:6] !== 2'b00) report("tuser pad", out_tuser[7:6], 0);
        end
      end
    end
  end
endmodule

// ===== tb/overlap_extension_index_map_test.sv =====
// Testbench top: stimulus, configuration phases, flow control and verdict.
`timescale 1ns / 1ps
module overlap_extension_index_map_test;
  import oeim_pkg::*;

  localparam int PIPE_DEPTH = 5 * 32 + 6;   // block latency at default width
  localparam int STALL_LIMIT = 20000;       // cycles with nothing accepted

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid, out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;

  // idling percentages per phase; hold_off forces a long receiver stall
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  overlap_extension_index_map dut (.*);

  overlap_extension_index_map_checker chk (.*);

  // receiver: random stalls, or a long hold-off while hold_off is set
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val; cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // one request on the input channel, with sender idling
  task automatic send_row(logic [31:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid(int cw, ch, px, py, ncx, ncy, nl);
    reg_write(REG_CELL_WIDTH, cw);
    reg_write(REG_CELL_HEIGHT, ch);
    reg_write(REG_PAD_X, px);
    reg_write(REG_PAD_Y, py);
    reg_write(REG_CELLS_ACROSS, ncx);
    reg_write(REG_CELLS_DOWN, ncy);
    reg_write(REG_LAYER_COUNT, nl);
  endtask

  // grid span so that most random rows land inside the padded grid
  function automatic logic [31:0] grid_row(int cw, ch, px, py, ncx, ncy, nl);
    longint unsigned span;
    span = longint'(nl) * (2 * px + cw) * (2 * py + ch) * ncx * ncy;
    if ($urandom_range(9) == 0 || span > 64'hFFFF_FFFF) return $urandom;
    return $urandom_range(32'(span - 1));
  endfunction

  int cw, ch, px, py, ncx, ncy, nl;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset grid, then a small padded grid covering every margin
    send_row(32'h0);
    send_row(32'hFFFF_FFFF);
    drain();
    set_grid(3, 2, 1, 1, 2, 2, 2);
    // 2 layers * 5 * 4 * 2 * 2 = 160 rows; corners, edges and wrap
    for (int r = 0; r < 16; r++) send_row(r * 11);
    send_row(32'hAAAA_AAAA);
    send_row(32'h5555_5555);
    drain();
    // single cell per axis, pad larger than cell, out-of-range clamps
    set_grid(2, 1, 3, 2, 1, 1, 0);
    for (int r = 0; r < 6; r++) send_row($urandom_range(300));
    drain();
    set_grid(2047, 0, 2047, 1500, 511, 0, 31);
    send_row(32'hFFFF_FFFF);
    send_row($urandom);
    drain();
    set_grid(1024, 1024, 1024, 1024, 256, 256, 16);
    send_row(32'hFFFF_FFFF);
    send_row(32'h8000_0000);
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (ph == 7) begin
        cw = 1024; ch = 1024; px = 1024; py = 0; ncx = 256; ncy = 256; nl = 16;
      end else begin
        cw = $urandom_range(1, 6); ch = $urandom_range(1, 6);
        px = $urandom_range(0, cw); py = $urandom_range(0, ch);
        ncx = $urandom_range(1, 4); ncy = $urandom_range(1, 4);
        nl = $urandom_range(1, 3);
      end
      set_grid(cw, ch, px, py, ncx, ncy, nl);
      for (int n = 0; n < 165; n++) begin
        // long receiver hold-off while the sender keeps offering rows
        if (ph == 2 && n == 10) fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        send_row(grid_row(cw, ch, px, py, ncx, ncy, nl));
      end
      // sender pauses until every result is back
      drain();
    end

    repeat (PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
